FILE: design/pfc_pkg.sv
// Shared types, register codes and format tables for the pixel format converter.
`timescale 1ns / 1ps

package pfc_pkg;

    // Palette size and the palette data word.
    localparam int PALETTE_DEPTH = 256;
    localparam int PIXEL_W       = 32;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SRC_BYTES  = 2'd0;
    localparam logic [1:0] CFG_SRC_LAYOUT = 2'd1;
    localparam logic [1:0] CFG_DST_BYTES  = 2'd2;
    localparam logic [1:0] CFG_DST_LAYOUT = 2'd3;

    // Request codes carried by an input beat.
    localparam logic REQ_PAL_WRITE = 1'b0;
    localparam logic REQ_CONVERT   = 1'b1;

    // Register values after reset.
    localparam logic [2:0] RST_SRC_BYTES  = 3'd4;
    localparam logic [1:0] RST_SRC_LAYOUT = 2'd1;
    localparam logic [2:0] RST_DST_BYTES  = 3'd4;
    localparam logic [1:0] RST_DST_LAYOUT = 2'd0;

    // Format selection handed to the conversion logic.
    typedef struct packed {
        logic [2:0] src_bytes;
        logic [1:0] src_layout;
        logic [2:0] dst_bytes;
        logic [1:0] dst_layout;
    } t_cfg;

    // Field shift per [bytes-1][layout][channel r,g,b,a].
    localparam logic [4:0] FMT_SHIFT [4][4][4] = '{
        '{ '{5'd0, 5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0, 5'd0},
           '{5'd0, 5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0, 5'd0} },
        '{ '{5'd11, 5'd5, 5'd0, 5'd0},  '{5'd0, 5'd5, 5'd11, 5'd0},
           '{5'd10, 5'd5, 5'd0, 5'd15}, '{5'd0, 5'd5, 5'd10, 5'd15} },
        '{ '{5'd16, 5'd8, 5'd0, 5'd0},  '{5'd0, 5'd8, 5'd16, 5'd0},
           '{5'd0, 5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0, 5'd0} },
        '{ '{5'd16, 5'd8, 5'd0, 5'd24}, '{5'd0, 5'd8, 5'd16, 5'd24},
           '{5'd16, 5'd8, 5'd0, 5'd24}, '{5'd0, 5'd8, 5'd16, 5'd24} }
    };

    // Field mask per [bytes-1][layout][channel r,g,b,a].
    localparam logic [31:0] FMT_MASK [4][4][4] = '{
        '{ '{32'h0, 32'h0, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0, 32'h0},
           '{32'h0, 32'h0, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0, 32'h0} },
        '{ '{32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'h0},
           '{32'h0000_001F, 32'h0000_07E0, 32'h0000_F800, 32'h0},
           '{32'h0000_7C00, 32'h0000_03E0, 32'h0000_001F, 32'h0000_8000},
           '{32'h0000_001F, 32'h0000_03E0, 32'h0000_7C00, 32'h0000_8000} },
        '{ '{32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'h0},
           '{32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000, 32'h0},
           '{32'h0, 32'h0, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0, 32'h0} },
        '{ '{32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000},
           '{32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000, 32'hFF00_0000},
           '{32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'h0},
           '{32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000, 32'h0} }
    };

    // Field width per [bytes-1][layout][channel r,g,b,a].
    localparam logic [3:0] FMT_WIDTH [4][4][4] = '{
        '{ '{4'd0, 4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0, 4'd0},
           '{4'd0, 4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0, 4'd0} },
        '{ '{4'd5, 4'd6, 4'd5, 4'd0}, '{4'd5, 4'd6, 4'd5, 4'd0},
           '{4'd5, 4'd5, 4'd5, 4'd1}, '{4'd5, 4'd5, 4'd5, 4'd1} },
        '{ '{4'd8, 4'd8, 4'd8, 4'd0}, '{4'd8, 4'd8, 4'd8, 4'd0},
           '{4'd0, 4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0, 4'd0} },
        '{ '{4'd8, 4'd8, 4'd8, 4'd8}, '{4'd8, 4'd8, 4'd8, 4'd8},
           '{4'd8, 4'd8, 4'd8, 4'd8}, '{4'd8, 4'd8, 4'd8, 4'd8} }
    };

    // Mask that keeps the low n bytes of a pixel word.
    function automatic logic [31:0] byte_mask(input logic [2:0] n);
        logic [31:0] m;
        unique case (n)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

FILE: design/pixel_format_converter_top.sv
// Top level of the pixel format converter: registers, palette and result stage.
//
//  Channel   Direction  Handshake                  Payload
//  in        to block   i_in_valid / o_in_stall    i_req_type, i_pixel_in, i_pal_index,
//                                                  i_pal_color
//  out       from block o_out_valid / i_out_stall  o_pixel_out
//  cfg       to block   i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One beat is taken every cycle unless o_in_stall is high. The palette read is
// registered at acceptance with the input stage, ahead of the result stage.
// Palette writes finish on the edge that accepts them and give no result beat.
// Reset is synchronous, sets the configuration to its reset values and clears both
// valid flags; the palette is not cleared and needs no sweep.
// A stall on the output holds the result and, once the middle stage is full, stalls input.
`timescale 1ns / 1ps

module pixel_format_converter_top #(
    parameter int PALETTE_DEPTH = pfc_pkg::PALETTE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [2:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [31:0] i_pixel_in,
    input  logic [7:0]  i_pal_index,
    input  logic [31:0] i_pal_color,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_pixel_out
);

    localparam int ADDR_W = $clog2(PALETTE_DEPTH);

    pfc_pkg::t_cfg r_cfg;
    logic          r_s1_valid;
    logic [31:0]   r_s1_pixel;
    logic          r_s1_pal_ok;
    logic          r_out_valid;
    logic [31:0]   r_out_pixel;

    logic          out_ready;
    logic          s1_adv;
    logic          in_acc;
    logic          wr_idx_ok;
    logic          rd_idx_ok;
    logic          pal_we;
    logic [31:0]   pal_rdata;
    logic [31:0]   pal_entry;
    logic          conv_valid;
    logic [31:0]   conv_pixel;

    // Configuration registers: the user writes them only while the block is idle, unchecked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_bytes  <= pfc_pkg::RST_SRC_BYTES;
            r_cfg.src_layout <= pfc_pkg::RST_SRC_LAYOUT;
            r_cfg.dst_bytes  <= pfc_pkg::RST_DST_BYTES;
            r_cfg.dst_layout <= pfc_pkg::RST_DST_LAYOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pfc_pkg::CFG_SRC_BYTES:  r_cfg.src_bytes  <= i_cfg_data;
                pfc_pkg::CFG_SRC_LAYOUT: r_cfg.src_layout <= i_cfg_data[1:0];
                pfc_pkg::CFG_DST_BYTES:  r_cfg.dst_bytes  <= i_cfg_data;
                pfc_pkg::CFG_DST_LAYOUT: r_cfg.dst_layout <= i_cfg_data[1:0];
                default:                 r_cfg            <= r_cfg;
            endcase
        end
    end

    // Flow control: each stage moves when the one after it can take a beat.
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s1_adv     = !r_s1_valid || out_ready;
    assign o_in_stall = !s1_adv;
    assign in_acc     = i_in_valid && s1_adv;

    // Palette indexes at or beyond the depth are ignored on write and read as zero.
    assign wr_idx_ok = ({1'b0, i_pal_index} < 9'(PALETTE_DEPTH));
    assign rd_idx_ok = ({1'b0, i_pixel_in[7:0]} < 9'(PALETTE_DEPTH));
    assign pal_we    = in_acc && (i_req_type == pfc_pkg::REQ_PAL_WRITE) && wr_idx_ok;

    pfc_palette #(
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (pal_we),
        .i_wr_addr (i_pal_index[ADDR_W-1:0]),
        .i_wr_data (i_pal_color),
        .i_rd_en   (s1_adv),
        .i_rd_addr (i_pixel_in[ADDR_W-1:0]),
        .o_rd_data (pal_rdata)
    );

    // Input stage: only convert beats travel on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= in_acc && (i_req_type == pfc_pkg::REQ_CONVERT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_pixel  <= i_pixel_in;
            r_s1_pal_ok <= rd_idx_ok;
        end
    end

    assign pal_entry = r_s1_pal_ok ? pal_rdata : 32'h0;

    pfc_convert u_convert (
        .i_cfg       (r_cfg),
        .i_pixel     (r_s1_pixel),
        .i_pal_entry (pal_entry),
        .o_valid     (conv_valid),
        .o_pixel     (conv_pixel)
    );

    // Result stage: unsupported formats give no result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid && conv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_out_pixel <= conv_pixel;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_out_pixel;

endmodule

FILE: design/pfc_palette.sv
// Palette memory: one write port and one registered read port.
`timescale 1ns / 1ps

module pfc_palette #(
    parameter  int DEPTH  = pfc_pkg::PALETTE_DEPTH,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [ADDR_W-1:0]           i_wr_addr,
    input  logic [pfc_pkg::PIXEL_W-1:0] i_wr_data,
    input  logic                        i_rd_en,
    input  logic [ADDR_W-1:0]           i_rd_addr,
    output logic [pfc_pkg::PIXEL_W-1:0] o_rd_data
);

    logic [pfc_pkg::PIXEL_W-1:0] r_mem [DEPTH];
    logic [pfc_pkg::PIXEL_W-1:0] r_rd_data;

    // Entries are written by palette beats; contents are undefined until then.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // The read data holds while the consuming stage is stalled.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/pfc_convert.sv
// Conversion logic: moves each colour channel from the source to the destination format.
`timescale 1ns / 1ps

module pfc_convert (
    input  pfc_pkg::t_cfg               i_cfg,
    input  logic [pfc_pkg::PIXEL_W-1:0] i_pixel,
    input  logic [pfc_pkg::PIXEL_W-1:0] i_pal_entry,
    output logic                        o_valid,
    output logic [pfc_pkg::PIXEL_W-1:0] o_pixel
);

    logic [1:0]  s_idx;
    logic [1:0]  d_idx;
    logic        is_pal;
    logic        src_ok;
    logic        dst_ok;
    logic        same_fmt;
    logic [31:0] src_word;
    logic [31:0] dst_mask;
    logic [31:0] chan [4];

    // Table rows and the cases that bypass the channel logic.
    assign s_idx    = 2'(i_cfg.src_bytes - 3'd1);
    assign d_idx    = 2'(i_cfg.dst_bytes - 3'd1);
    assign is_pal   = (i_cfg.src_bytes == 3'd1);
    assign src_ok   = (i_cfg.src_bytes >= 3'd1) && (i_cfg.src_bytes <= 3'd4);
    assign dst_ok   = (i_cfg.dst_bytes >= 3'd2) && (i_cfg.dst_bytes <= 3'd4);
    assign same_fmt = (i_cfg.src_bytes == i_cfg.dst_bytes)
                   && (i_cfg.src_layout == i_cfg.dst_layout) && src_ok;
    assign src_word = i_pixel & pfc_pkg::byte_mask(i_cfg.src_bytes);
    assign dst_mask = pfc_pkg::byte_mask(i_cfg.dst_bytes);

    // One mover per channel; palette bytes act as 8-bit fields at shift zero.
    for (genvar gc = 0; gc < 4; gc++) begin : g_chan
        logic [31:0]       src_val;
        logic [4:0]        ss;
        logic [3:0]        sw;
        logic [4:0]        ds;
        logic [3:0]        dw;
        logic [31:0]       dm;
        logic signed [6:0] shr;
        logic signed [6:0] nshr;
        logic              far;
        logic              fill;
        logic [31:0]       moved;

        assign src_val = is_pal ? {24'd0, i_pal_entry[8*gc +: 8]} : src_word;
        assign ss      = is_pal ? 5'd0 : pfc_pkg::FMT_SHIFT[s_idx][i_cfg.src_layout][gc];
        assign sw      = is_pal ? 4'd8 : pfc_pkg::FMT_WIDTH[s_idx][i_cfg.src_layout][gc];
        assign ds      = pfc_pkg::FMT_SHIFT[d_idx][i_cfg.dst_layout][gc];
        assign dw      = pfc_pkg::FMT_WIDTH[d_idx][i_cfg.dst_layout][gc];
        assign dm      = pfc_pkg::FMT_MASK[d_idx][i_cfg.dst_layout][gc];

        // Right move by the shift difference less the growth in width.
        assign shr  = $signed(7'(ss) + 7'(sw) - 7'(ds) - 7'(dw));
        assign nshr = -shr;
        assign far  = (shr >= 7'sd32) || (nshr >= 7'sd32);

        always_comb begin
            if (far) begin
                moved = '0;
            end else if (shr >= 7'sd0) begin
                moved = src_val >> shr[4:0];
            end else begin
                moved = src_val << nshr[4:0];
            end
        end

        // A source without alpha gives full alpha in the destination.
        assign fill = (gc == 3) && !is_pal
                   && (pfc_pkg::FMT_MASK[s_idx][i_cfg.src_layout][gc] == 32'h0);
        assign chan[gc] = fill ? dm : (moved & dm);
    end

    // Merge the channels, or pass equal formats through, and keep only the destination bytes.
    always_comb begin
        o_valid = same_fmt || (src_ok && dst_ok);
        if (same_fmt) begin
            o_pixel = i_pixel & dst_mask;
        end else begin
            o_pixel = (chan[0] | chan[1] | chan[2] | chan[3]) & dst_mask;
        end
    end

endmodule

FILE: design/pfc_checker.sv
// Port-level checks on the pixel format converter, bound to its top level.
`timescale 1ns / 1ps

module pfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_req_type,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_pixel_out
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_pixel_out))
        else $error("result value changed while stalled");

    // The input side stalls only behind a stalled, full result stage.
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    // A fresh result follows an accepted convert beat.
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall && i_req_type, 2))
        else $error("result beat without a matching convert beat");

endmodule

bind pixel_format_converter_top pfc_checker u_pfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_req_type  (i_req_type),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_pixel_out (o_pixel_out)
);

FILE: verif/pixel_format_converter_top_test.sv
// Self-checking testbench for the pixel format converter: palette loads and pixel conversions.
`timescale 1ns / 1ps

module pixel_format_converter_top_test;

    // Cycles without any accepted beat before the run is declared hung.
    localparam int HANG_LIMIT   = 3000;
    // Cycles allowed after the last expected pixel for beats that give no result.
    localparam int DRAIN_CYCLES = 6;
    localparam int ITEM_TARGET  = 1300;

    // Channel positions in the per-format tables are red, green, blue, alpha.
    // Tables are indexed [bytes-1][layout][channel].
    localparam int CH_SHIFT [4][4][4] = '{
        '{ '{0, 0, 0, 0},    '{0, 0, 0, 0},    '{0, 0, 0, 0},     '{0, 0, 0, 0} },
        '{ '{11, 5, 0, 0},   '{0, 5, 11, 0},   '{10, 5, 0, 15},   '{0, 5, 10, 15} },
        '{ '{16, 8, 0, 0},   '{0, 8, 16, 0},   '{0, 0, 0, 0},     '{0, 0, 0, 0} },
        '{ '{16, 8, 0, 24},  '{0, 8, 16, 24},  '{16, 8, 0, 24},   '{0, 8, 16, 24} }
    };
    localparam int CH_WIDTH [4][4][4] = '{
        '{ '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0} },
        '{ '{5, 6, 5, 0}, '{5, 6, 5, 0}, '{5, 5, 5, 1}, '{5, 5, 5, 1} },
        '{ '{8, 8, 8, 0}, '{8, 8, 8, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0} },
        '{ '{8, 8, 8, 8}, '{8, 8, 8, 8}, '{8, 8, 8, 8}, '{8, 8, 8, 8} }
    };
    localparam logic [31:0] CH_MASK [4][4][4] = '{
        '{ '{32'h0, 32'h0, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0, 32'h0},
           '{32'h0, 32'h0, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0, 32'h0} },
        '{ '{32'hF800, 32'h07E0, 32'h001F, 32'h0},
           '{32'h001F, 32'h07E0, 32'hF800, 32'h0},
           '{32'h7C00, 32'h03E0, 32'h001F, 32'h8000},
           '{32'h001F, 32'h03E0, 32'h7C00, 32'h8000} },
        '{ '{32'hFF0000, 32'h00FF00, 32'h0000FF, 32'h0},
           '{32'h0000FF, 32'h00FF00, 32'hFF0000, 32'h0},
           '{32'h0, 32'h0, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0, 32'h0} },
        '{ '{32'h00FF0000, 32'h0000FF00, 32'h000000FF, 32'hFF000000},
           '{32'h000000FF, 32'h0000FF00, 32'h00FF0000, 32'hFF000000},
           '{32'h00FF0000, 32'h0000FF00, 32'h000000FF, 32'h0},
           '{32'h000000FF, 32'h0000FF00, 32'h00FF0000, 32'h0} }
    };

    typedef struct {
        logic        req_type;
        logic [31:0] pixel;
        logic [7:0]  pal_index;
        logic [31:0] pal_color;
    } t_pix_req;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PATTERN
    } t_stall_mode;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_idx   = pfc_pkg::CFG_SRC_BYTES;
    logic [2:0]  i_cfg_data  = 3'd0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic        i_req_type  = pfc_pkg::REQ_PAL_WRITE;
    logic [31:0] i_pixel_in  = 32'd0;
    logic [7:0]  i_pal_index = 8'd0;
    logic [31:0] i_pal_color = 32'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_pixel_out;

    // Beats waiting to be driven and converted pixels waiting to come out.
    t_pix_req    pending_beats [$];
    logic [31:0] expected_pixels [$];

    // Predictor state: current formats and palette contents.
    pfc_pkg::t_cfg fmt;
    logic [31:0]   pal_mem [pfc_pkg::PALETTE_DEPTH];

    // Stimulus side bookkeeping of which palette entries hold data.
    bit          pal_written [pfc_pkg::PALETTE_DEPTH];
    logic [7:0]  pal_indices [$];

    int          items_queued = 0;
    int          mismatches   = 0;
    int          idle_cycles  = 0;
    int          burst_left   = 0;
    int          gap_left     = 0;
    int          stall_left   = 0;
    t_stall_mode stall_mode   = STALL_NONE;
    logic [7:0]  stall_phase  = 8'd0;
    t_pix_req    next_beat;
    logic [31:0] want_pixel;
    bit          beat_taken;

    pixel_format_converter_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_pixel_in  (i_pixel_in),
        .i_pal_index (i_pal_index),
        .i_pal_color (i_pal_color),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pixel_out (o_pixel_out)
    );

    always #5 i_clk = ~i_clk;

    // Keeps the low n bytes of a word; four or more keeps all of it.
    function automatic logic [31:0] keep_bytes(input logic [2:0] n);
        if (n >= 3'd4) return 32'hFFFF_FFFF;
        return (32'd1 << (8 * n)) - 32'd1;
    endfunction

    // Moves a channel right by shr (left when negative) and masks it; long moves give zero.
    function automatic logic [31:0] move_channel(input logic [31:0] v, input int shr,
                                                 input logic [31:0] mask);
        if (shr >= 32 || shr <= -32) return 32'd0;
        if (shr >= 0) return (v >> shr) & mask;
        return (v << (-shr)) & mask;
    endfunction

    // Works out the converted pixel under the current formats; returns 0 when none is due.
    function automatic bit convert_pixel(input logic [31:0] pix, output logic [31:0] px);
        int          s;
        int          sl;
        int          d;
        int          dl;
        int          shr;
        logic [31:0] acc;
        logic [31:0] srcv;
        logic [31:0] entry;
        px  = 32'd0;
        acc = 32'd0;
        if (fmt.src_bytes == fmt.dst_bytes && fmt.src_layout == fmt.dst_layout &&
            fmt.src_bytes >= 3'd1 && fmt.src_bytes <= 3'd4) begin
            px = pix & keep_bytes(fmt.dst_bytes);
            return 1'b1;
        end
        if (fmt.src_bytes < 3'd1 || fmt.src_bytes > 3'd4 ||
            fmt.dst_bytes < 3'd2 || fmt.dst_bytes > 3'd4) begin
            return 1'b0;
        end
        d  = int'(fmt.dst_bytes) - 1;
        dl = int'(fmt.dst_layout);
        if (fmt.src_bytes == 3'd1) begin
            // Indexed source: every palette byte acts as an 8-bit field at shift zero.
            entry = pal_mem[pix[7:0]];
            for (int c = 0; c < 4; c++) begin
                shr = -CH_SHIFT[d][dl][c] - (CH_WIDTH[d][dl][c] - 8);
                acc |= move_channel({24'd0, entry[8*c +: 8]}, shr, CH_MASK[d][dl][c]);
            end
        end else begin
            s    = int'(fmt.src_bytes) - 1;
            sl   = int'(fmt.src_layout);
            srcv = pix & keep_bytes(fmt.src_bytes);
            for (int c = 0; c < 4; c++) begin
                shr = (CH_SHIFT[s][sl][c] - CH_SHIFT[d][dl][c]) -
                      (CH_WIDTH[d][dl][c] - CH_WIDTH[s][sl][c]);
                // A source with no alpha field gives opaque alpha.
                if (c == 3 && CH_MASK[s][sl][3] == 32'd0)
                    acc |= CH_MASK[d][dl][3];
                else
                    acc |= move_channel(srcv, shr, CH_MASK[d][dl][c]);
            end
        end
        px = acc & keep_bytes(fmt.dst_bytes);
        return 1'b1;
    endfunction

    // Random word that now and then favours all-zero, all-one, one-hot and one-cold patterns.
    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd1 << $urandom_range(0, 31);
            3:       return ~(32'd1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected %08h, got %08h", $realtime, what, want, got);
    endtask

    task automatic push_write(input logic [7:0] idx, input logic [31:0] colour);
        t_pix_req r;
        if (!pal_written[idx]) begin
            pal_written[idx] = 1'b1;
            pal_indices.push_back(idx);
        end
        r.req_type  = pfc_pkg::REQ_PAL_WRITE;
        r.pixel     = $urandom;
        r.pal_index = idx;
        r.pal_color = colour;
        pending_beats.push_back(r);
        items_queued++;
    endtask

    // Indexed sources only ever look up palette entries that already hold data.
    task automatic push_convert(input logic [31:0] pix);
        t_pix_req r;
        if (fmt.src_bytes == 3'd1 && !pal_written[pix[7:0]]) begin
            if (pal_indices.size() == 0)
                push_write(8'($urandom_range(0, 255)), random_word());
            pix[7:0] = pal_indices[$urandom_range(0, pal_indices.size() - 1)];
        end
        r.req_type  = pfc_pkg::REQ_CONVERT;
        r.pixel     = pix;
        r.pal_index = 8'($urandom);
        r.pal_color = $urandom;
        pending_beats.push_back(r);
        items_queued++;
    endtask

    // Waits until every beat is in and every pixel is out, then lets the pipeline drain.
    task automatic settle();
        while (pending_beats.size() != 0 || i_in_valid || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes all four format registers once the block is idle.
    task automatic set_formats(input logic [2:0] sb, input logic [1:0] sl,
                               input logic [2:0] db, input logic [1:0] dl);
        settle();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= pfc_pkg::CFG_SRC_BYTES;
        i_cfg_data <= sb;
        fmt.src_bytes = sb;
        @(posedge i_clk);
        i_cfg_idx  <= pfc_pkg::CFG_SRC_LAYOUT;
        i_cfg_data <= {1'($urandom_range(0, 1)), sl};
        fmt.src_layout = sl;
        @(posedge i_clk);
        i_cfg_idx  <= pfc_pkg::CFG_DST_BYTES;
        i_cfg_data <= db;
        fmt.dst_bytes = db;
        @(posedge i_clk);
        i_cfg_idx  <= pfc_pkg::CFG_DST_LAYOUT;
        i_cfg_data <= {1'($urandom_range(0, 1)), dl};
        fmt.dst_layout = dl;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Input driver: beats go out in bursts separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                next_beat = pending_beats.pop_front();
                i_req_type  <= next_beat.req_type;
                i_pixel_in  <= next_beat.pixel;
                i_pal_index <= next_beat.pal_index;
                i_pal_color <= next_beat.pal_color;
                i_in_valid  <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure: modes of random length, from none to heavy to a fixed pattern.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 160);
        end else begin
            stall_left--;
        end
        stall_phase++;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= (stall_phase[2:0] >= 3'd5);
        endcase
    end

    // Monitor: checks each pixel beat out, then predicts from each beat in.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            beat_taken = 1'b0;
            if (o_out_valid && !i_out_stall) begin
                beat_taken = 1'b1;
                if (expected_pixels.size() == 0)
                    note_mismatch("pixel with none expected", 32'd0, o_pixel_out);
                else if (o_pixel_out !== expected_pixels[0])
                    note_mismatch("pixel_out", expected_pixels.pop_front(), o_pixel_out);
                else
                    void'(expected_pixels.pop_front());
            end
            if (i_in_valid && !o_in_stall) begin
                beat_taken = 1'b1;
                if (i_req_type == pfc_pkg::REQ_PAL_WRITE)
                    pal_mem[i_pal_index] = i_pal_color;
                else if (convert_pixel(i_pixel_in, want_pixel))
                    expected_pixels.push_back(want_pixel);
            end
            idle_cycles = beat_taken ? 0 : idle_cycles + 1;
            if (idle_cycles >= HANG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        logic [2:0] sb;
        logic [2:0] db;
        logic [1:0] sl;
        logic [1:0] dl;
        int         n;
        fmt = '{pfc_pkg::RST_SRC_BYTES, pfc_pkg::RST_SRC_LAYOUT,
                pfc_pkg::RST_DST_BYTES, pfc_pkg::RST_DST_LAYOUT};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset formats: 8888 BGR to 8888 RGB, plus palette loads at both ends.
        push_write(8'h00, 32'h0000_0000);
        push_write(8'hFF, 32'hFFFF_FFFF);
        push_write(8'h5A, 32'h80FF_4020);
        push_write(8'hA5, 32'h7F00_BFDF);
        push_convert(32'h0000_0000);
        push_convert(32'hFFFF_FFFF);
        push_convert(32'h1234_5678);
        push_convert(32'h8000_0001);

        // Indexed source into 565 and into 555 with alpha.
        set_formats(3'd1, 2'd0, 3'd2, 2'd0);
        push_convert(32'h0000_0000);
        push_convert(32'hFFFF_FFFF);
        push_convert(32'h0000_005A);
        set_formats(3'd1, 2'd0, 3'd2, 2'd2);
        push_convert(32'h0000_00A5);
        push_convert(32'hDEAD_BE5A);

        // Widening 565 to 8888 with opaque alpha filled in.
        set_formats(3'd2, 2'd0, 3'd4, 2'd0);
        push_convert(32'h0000_FFFF);
        push_convert(32'h1234_F81F);

        // Equal formats pass through with the upper byte cleared.
        set_formats(3'd3, 2'd1, 3'd3, 2'd1);
        push_convert(32'hFFFF_FFFF);

        // Empty three-byte layouts as source and as destination.
        set_formats(3'd3, 2'd2, 3'd4, 2'd1);
        push_convert(32'h00AB_CDEF);
        set_formats(3'd4, 2'd0, 3'd3, 2'd3);
        push_convert(32'hFFFF_FFFF);

        // Source alpha moved far enough to fall off the word.
        set_formats(3'd4, 2'd0, 3'd2, 2'd0);
        push_convert(32'hFF00_FF00);

        // Unsupported sizes give nothing, except equal formats that are in range.
        set_formats(3'd0, 2'd1, 3'd4, 2'd0);
        push_convert(32'h0000_0001);
        set_formats(3'd4, 2'd1, 3'd1, 2'd0);
        push_convert(32'h0000_0002);
        set_formats(3'd7, 2'd3, 3'd7, 2'd3);
        push_convert(32'hFFFF_FFFF);
        set_formats(3'd1, 2'd0, 3'd1, 2'd0);
        push_convert(32'hC0FF_EE5A);

        // Random phases: mostly supported formats, some equal, some fully arbitrary.
        while (items_queued < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0: begin
                    sb = 3'($urandom_range(0, 7));
                    db = 3'($urandom_range(0, 7));
                    sl = 2'($urandom_range(0, 3));
                    dl = 2'($urandom_range(0, 3));
                end
                1: begin
                    sb = 3'($urandom_range(1, 4));
                    db = sb;
                    sl = 2'($urandom_range(0, 3));
                    dl = sl;
                end
                default: begin
                    sb = 3'($urandom_range(1, 4));
                    db = 3'($urandom_range(2, 4));
                    sl = 2'($urandom_range(0, 3));
                    dl = 2'($urandom_range(0, 3));
                end
            endcase
            set_formats(sb, sl, db, dl);
            n = $urandom_range(15, 60);
            repeat (n) begin
                if ($urandom_range(0, 99) < 15)
                    push_write(8'($urandom_range(0, 255)), random_word());
                else
                    push_convert(random_word());
            end
        end

        settle();
        mismatches += expected_pixels.size();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/pfc_pkg.sv
design/pfc_palette.sv
design/pfc_convert.sv
design/pixel_format_converter_top.sv
design/pfc_checker.sv
verif/pixel_format_converter_top_test.sv
